// File: src/abpdu_pkg.sv
// Package for the ADMM box projection and dual update block.
// Holds the data width, parameter defaults, register and status codes, the
// stored entry and update result types, and the saturation helpers.
package abpdu_pkg;

  // Fixed field widths of the datapath.
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned RES_WIDTH  = 16;
  localparam int unsigned CFG_WIDTH  = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BOUND_NUM  = 4;
  localparam int unsigned FRAC_BITS  = 12;

  // Defaults for the top-level parameters.
  localparam int unsigned HORIZON_STEPS_DEFAULT = 16;
  localparam int unsigned MAX_INPUTS_DEFAULT    = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgLowerBounds = 3'd0,
    CfgUpperBounds = 3'd1,
    CfgPenaltyRho  = 3'd2,
    CfgTolPrimal   = 3'd3,
    CfgTolDual     = 3'd4,
    CfgDivLimit    = 3'd5
  } cfg_idx_e;

  // Termination status codes.
  typedef enum logic [1:0] {
    StUnsolved  = 2'd0,
    StSolved    = 2'd1,
    StDiverging = 2'd2
  } status_e;

  // One stored entry: dual and slack of one horizon step and channel.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dual;
    logic signed [DATA_WIDTH-1:0] slack;
  } entry_t;

  // Result of one element update.
  typedef struct packed {
    entry_t                 entry;
    logic [RES_WIDTH-1:0]   primal_res;
    logic [RES_WIDTH-1:0]   dual_res;
  } upd_t;

  // Saturate a sum of two data words to the signed data range.
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
    input logic signed [DATA_WIDTH:0] v
  );
    logic signed [DATA_WIDTH-1:0] r;
    if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
      r = v[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Magnitude of a difference of two data words; it always fits the word.
  function automatic logic [RES_WIDTH-1:0] abs_mag(
    input logic signed [DATA_WIDTH:0] v
  );
    logic signed [DATA_WIDTH:0] n;
    n = -v;
    return v[DATA_WIDTH] ? RES_WIDTH'(n) : RES_WIDTH'(v);
  endfunction

endpackage

// File: src/abpdu_update.sv
// Element update of the box projection: adds the control value to the dual,
// clamps to the bounds, forms the new dual and both residual magnitudes.
// Depends on abpdu_pkg.
module abpdu_update (
  input  abpdu_pkg::entry_t                         old_i,
  input  logic signed [abpdu_pkg::DATA_WIDTH-1:0]   u_i,
  input  logic signed [abpdu_pkg::DATA_WIDTH-1:0]   lo_i,
  input  logic signed [abpdu_pkg::DATA_WIDTH-1:0]   hi_i,
  output abpdu_pkg::upd_t                           upd_o
);
  import abpdu_pkg::*;

  logic signed [DATA_WIDTH:0]   sum;
  logic signed [DATA_WIDTH:0]   diff;
  logic signed [DATA_WIDTH:0]   pdiff;
  logic signed [DATA_WIDTH:0]   ddiff;
  logic signed [DATA_WIDTH-1:0] s_sat;
  logic signed [DATA_WIDTH-1:0] z_new;

  // Saturated sum, clamp (lower first, then upper) and the residual differences.
  always_comb begin
    sum   = {old_i.dual[DATA_WIDTH-1], old_i.dual} + {u_i[DATA_WIDTH-1], u_i};
    s_sat = sat_data(sum);
    z_new = (s_sat < lo_i) ? lo_i : s_sat;
    if (z_new > hi_i) begin
      z_new = hi_i;
    end
    diff  = {s_sat[DATA_WIDTH-1], s_sat} - {z_new[DATA_WIDTH-1], z_new};
    pdiff = {u_i[DATA_WIDTH-1], u_i} - {z_new[DATA_WIDTH-1], z_new};
    ddiff = {z_new[DATA_WIDTH-1], z_new} - {old_i.slack[DATA_WIDTH-1], old_i.slack};

    upd_o.entry.dual  = sat_data(diff);
    upd_o.entry.slack = z_new;
    upd_o.primal_res  = abs_mag(pdiff);
    upd_o.dual_res    = abs_mag(ddiff);
  end

endmodule

// File: src/admm_box_projection_dual_update.sv
// ADMM box projection and dual update: slack/dual store, residual tracking
// and termination check. Depends on abpdu_pkg and abpdu_update.
//
// Usage. One control element enters per input beat (valid/ready), tagged with
// its horizon step, channel and pass markers. Each beat produces exactly one
// output beat carrying the new slack, the new dual, the running residual
// maxima and the latched solve status. Configuration registers are written
// through a plain write port (enable, index, data) while the block is idle.
//
// Timing. The slack and dual of every entry sit in one synchronous memory.
// An element reads its entry on acceptance, is updated and written back as it
// leaves stage 1, and its result passes through stage 2 into the output
// register. Back-to-back elements on the same entry are served by a
// forwarding path, so one element is accepted every cycle while the output is not stalled.
//
// Reset. The memory is cleared by a sweep over all HORIZON_STEPS * MAX_INPUTS
// entries (64 by default), during which in_ready_o stays low.
// When the receiver stalls, the output beat holds, the two inner stages still
// fill, and in_ready_o drops once they are full.
module admm_box_projection_dual_update #(
  parameter int unsigned HORIZON_STEPS = abpdu_pkg::HORIZON_STEPS_DEFAULT,
  parameter int unsigned MAX_INPUTS    = abpdu_pkg::MAX_INPUTS_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Configuration write port.
  input  logic                                     cfg_we_i,
  input  logic [abpdu_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [abpdu_pkg::CFG_WIDTH-1:0]          cfg_wdata_i,
  // Input channel.
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [abpdu_pkg::DATA_WIDTH-1:0]  control_value_i,
  input  logic [3:0]                               step_index_i,
  input  logic [1:0]                               channel_i,
  input  logic                                     first_of_pass_i,
  input  logic                                     last_of_pass_i,
  input  logic                                     check_now_i,
  // Output channel.
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [abpdu_pkg::DATA_WIDTH-1:0]  slack_value_o,
  output logic signed [abpdu_pkg::DATA_WIDTH-1:0]  dual_value_o,
  output logic [abpdu_pkg::RES_WIDTH-1:0]          primal_residual_o,
  output logic [abpdu_pkg::RES_WIDTH-1:0]          dual_residual_o,
  output logic [1:0]                               solve_status_o,
  output logic                                     pass_done_o
);
  import abpdu_pkg::*;

  localparam int unsigned DEPTH    = HORIZON_STEPS * MAX_INPUTS;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW       = (HORIZON_STEPS > 1) ? $clog2(HORIZON_STEPS) : 1;
  localparam int unsigned STEP_NUM = 16;
  localparam int unsigned PROD_W   = 2 * RES_WIDTH;

  // Configuration registers.
  logic [CFG_WIDTH-1:0] lower_bounds_q, upper_bounds_q;
  logic [RES_WIDTH-1:0] rho_q, tol_primal_q, tol_dual_q, div_limit_q;

  // Clearing sweep after reset.
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  // Stage 1: entry read, waiting for update.
  logic                          s1_valid_q;
  logic [AW-1:0]                 s1_addr_q;
  logic [1:0]                    s1_ch_q;
  logic signed [DATA_WIDTH-1:0]  s1_u_q;
  logic                          s1_first_q, s1_last_q, s1_check_q;
  entry_t                        rdata_q;
  logic                          fwd_hit_q;
  entry_t                        fwd_q;

  // Stage 2: updated element, waiting for residual tracking.
  logic  s2_valid_q;
  upd_t  s2_upd_q;
  logic  s2_first_q, s2_last_q, s2_check_q;

  // Output register and pass state.
  logic                          out_valid_q;
  logic signed [DATA_WIDTH-1:0]  out_slack_q, out_dual_q;
  logic [RES_WIDTH-1:0]          out_pres_q, out_dres_q;
  logic                          out_last_q;
  logic [RES_WIDTH-1:0]          primal_max_q, dual_max_q;
  status_e                       status_q;

  // Handshake and advance conditions.
  logic out_free, s2_ready, s1_ready, s1_adv, s2_adv, in_acc;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    s2_ready = !s2_valid_q || out_free;
    s1_ready = !s1_valid_q || s2_ready;
    s1_adv   = s1_valid_q && s2_ready;
    s2_adv   = s2_valid_q && out_free;
    in_acc   = in_valid_i && in_ready_o;
  end

  assign in_ready_o = s1_ready && !clearing_q;

  // Wrap step and channel to the store dimensions through small tables.
  logic [SW-1:0] step_wrap_tbl [STEP_NUM];
  logic [1:0]    ch_wrap_tbl   [BOUND_NUM];

  for (genvar g = 0; g < STEP_NUM; g++) begin : g_step_wrap
    assign step_wrap_tbl[g] = SW'(g % HORIZON_STEPS);
  end
  for (genvar g = 0; g < BOUND_NUM; g++) begin : g_ch_wrap
    assign ch_wrap_tbl[g] = 2'(g % MAX_INPUTS);
  end

  logic [1:0]    in_ch;
  logic [AW-1:0] rd_addr;

  always_comb begin
    in_ch   = ch_wrap_tbl[channel_i];
    rd_addr = AW'(step_wrap_tbl[step_index_i]) * AW'(MAX_INPUTS) + AW'(in_ch);
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_bounds_q <= '0;
      upper_bounds_q <= '0;
      rho_q          <= RES_WIDTH'(4096);
      tol_primal_q   <= RES_WIDTH'(4);
      tol_dual_q     <= RES_WIDTH'(4);
      div_limit_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLowerBounds: lower_bounds_q <= cfg_wdata_i;
        CfgUpperBounds: upper_bounds_q <= cfg_wdata_i;
        CfgPenaltyRho:  rho_q          <= cfg_wdata_i[RES_WIDTH-1:0];
        CfgTolPrimal:   tol_primal_q   <= cfg_wdata_i[RES_WIDTH-1:0];
        CfgTolDual:     tol_dual_q     <= cfg_wdata_i[RES_WIDTH-1:0];
        CfgDivLimit:    div_limit_q    <= cfg_wdata_i[RES_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // Stage 1 update: pick the forwarded entry when the previous element wrote
  // the same entry on the edge this one was read.
  entry_t                       s1_old;
  logic signed [DATA_WIDTH-1:0] s1_lo, s1_hi;
  upd_t                         s1_upd;

  always_comb begin
    s1_old = fwd_hit_q ? fwd_q : rdata_q;
    s1_lo  = lower_bounds_q[s1_ch_q * DATA_WIDTH +: DATA_WIDTH];
    s1_hi  = upper_bounds_q[s1_ch_q * DATA_WIDTH +: DATA_WIDTH];
  end

  abpdu_update u_update (
    .old_i (s1_old),
    .u_i   (s1_u_q),
    .lo_i  (s1_lo),
    .hi_i  (s1_hi),
    .upd_o (s1_upd)
  );

  // Store write port: the clearing sweep or the stage 1 write-back.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  always_comb begin
    mem_we    = clearing_q || s1_adv;
    mem_waddr = clearing_q ? clr_addr_q : s1_addr_q;
    mem_wdata = clearing_q ? entry_t'('0) : s1_upd.entry;
  end

  // Slack and dual store with registered read.
  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Stage 1 registers, loaded on acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_adv && (s1_addr_q == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q  <= rd_addr;
      s1_ch_q    <= in_ch;
      s1_u_q     <= control_value_i;
      s1_first_q <= first_of_pass_i;
      s1_last_q  <= last_of_pass_i;
      s1_check_q <= check_now_i;
      fwd_q      <= s1_upd.entry;
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_upd_q   <= s1_upd;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_check_q <= s1_check_q;
    end
  end

  // Running maxima, rho scaling on the last element and termination check.
  logic [RES_WIDTH-1:0] pm_base, dm_base, pm_new, dm_new, dual_scaled, dres_out;
  logic [PROD_W-1:0]    prod;
  status_e              status_d;

  always_comb begin
    pm_base  = s2_first_q ? '0 : primal_max_q;
    dm_base  = s2_first_q ? '0 : dual_max_q;
    pm_new   = (s2_upd_q.primal_res > pm_base) ? s2_upd_q.primal_res : pm_base;
    dm_new   = (s2_upd_q.dual_res > dm_base) ? s2_upd_q.dual_res : dm_base;
    prod     = PROD_W'(dm_new) * PROD_W'(rho_q);
    dual_scaled = (|prod[PROD_W-1:RES_WIDTH+FRAC_BITS]) ? '1
                : prod[RES_WIDTH+FRAC_BITS-1:FRAC_BITS];
    dres_out = s2_last_q ? dual_scaled : dm_new;
    status_d = status_q;
    if (s2_last_q && s2_check_q) begin
      priority if (pm_new > div_limit_q || dual_scaled > div_limit_q) begin
        status_d = StDiverging;
      end else if (pm_new < tol_primal_q && dual_scaled < tol_dual_q) begin
        status_d = StSolved;
      end else begin
        status_d = StUnsolved;
      end
    end
  end

  // Output register and pass state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      primal_max_q <= '0;
      dual_max_q   <= '0;
      status_q     <= StUnsolved;
    end else begin
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
      if (s2_adv) begin
        primal_max_q <= pm_new;
        dual_max_q   <= dm_new;
        status_q     <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_slack_q <= s2_upd_q.entry.slack;
      out_dual_q  <= s2_upd_q.entry.dual;
      out_pres_q  <= pm_new;
      out_dres_q  <= dres_out;
      out_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign slack_value_o     = out_slack_q;
  assign dual_value_o      = out_dual_q;
  assign primal_residual_o = out_pres_q;
  assign dual_residual_o   = out_dres_q;
  assign solve_status_o    = status_q;
  assign pass_done_o       = out_last_q;

endmodule
